>>> sv/integer_to_radix_digits_unit_assert.svh
// assertion macros shared by the converter rtl
`ifndef INTEGER_TO_RADIX_DIGITS_UNIT_ASSERT_SVH
`define INTEGER_TO_RADIX_DIGITS_UNIT_ASSERT_SVH

// condition and consequence in the same cycle
`define ITRD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the cycle after the condition
`define ITRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/itrd_pkg.sv
`default_nettype none

package itrd_pkg;

    localparam int VALUE_BITS_DEF = 31;

    localparam int NUMBER_W  = 31;
    localparam int S_TDATA_W = 32;
    localparam int CHAR_W    = 7;
    localparam int M_TDATA_W = 8;
    localparam int RADIX_W   = 5;
    localparam int DIGIT_W   = 4;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_A        = 7'd65;
    localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 4'd10;

    // register index, taken from paddr[2]
    localparam logic REG_RADIX = 1'b0;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_CONV,
        CELL_SHIFT
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t           mode;
        logic [RADIX_W-1:0]   radix;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_STRIP,
        ST_EMIT
    } state_t;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d >= DECIMAL_LIMIT) begin
            c = CHAR_A + CHAR_W'(d - DECIMAL_LIMIT);
        end else begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> sv/itrd_cell.sv
`default_nettype none

// one digit position: doubles its digit plus the incoming carry modulo the radix, or clears, holds or shifts it in
module itrd_cell (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire  itrd_pkg::cell_ctrl_t     ctrl,
    input  wire                            carry_in_valid,
    input  wire                            carry_in,
    input  wire  [itrd_pkg::DIGIT_W-1:0]   shift_in,
    output logic [itrd_pkg::DIGIT_W-1:0]   digit,
    output logic                           carry_out_valid,
    output logic                           carry_out
);

    logic [itrd_pkg::DIGIT_W-1:0] digit_reg, digit_next;
    logic                         carry_valid_reg, carry_valid_next;
    logic                         carry_reg, carry_next;
    logic [itrd_pkg::RADIX_W-1:0] sum;
    logic [itrd_pkg::RADIX_W-1:0] diff;
    logic                         ge;

    always_comb begin
        sum  = {digit_reg, carry_in};
        ge   = (sum >= ctrl.radix);
        diff = sum - ctrl.radix;

        digit_next       = digit_reg;
        carry_valid_next = 1'b0;
        carry_next       = ge;
        case (ctrl.mode)
            itrd_pkg::CELL_CLEAR: begin
                digit_next = '0;
            end
            itrd_pkg::CELL_CONV: begin
                carry_valid_next = carry_in_valid;
                if (carry_in_valid) begin
                    digit_next = ge ? diff[itrd_pkg::DIGIT_W-1:0]
                                    : sum[itrd_pkg::DIGIT_W-1:0];
                end
            end
            itrd_pkg::CELL_SHIFT: begin
                digit_next = shift_in;
            end
            default: begin
                digit_next = digit_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_valid_reg <= 1'b0;
        end else begin
            carry_valid_reg <= carry_valid_next;
        end
        digit_reg <= digit_next;
        carry_reg <= carry_next;
    end

    assign digit           = digit_reg;
    assign carry_out_valid = carry_valid_reg;
    assign carry_out       = carry_reg;

endmodule

`default_nettype wire

>>> sv/integer_to_radix_digits_unit.sv
// Converts one non-negative integer per input item into its digits in the base held in the
// radix register (2 to 16; 0 and 1 act as 2, 17 to 31 act as 16), sent most significant
// first as ASCII '0'-'9' and 'A'-'F', one output item per digit, with m_tlast on the final
// digit; zero gives the single digit '0'. Only the low VALUE_BITS bits of number_in are used.
// The number is shifted MSB first into a row of VALUE_BITS digit cells whose carries ripple
// one cell per cycle; leading zeros are then shifted out of the row and each digit shifted
// to the output register whenever that register is empty or being read, so output stalls
// hold the emission. One item is handled at a time; the next item is taken as soon as the
// last digit sits in the output register. The radix register is at byte address 0; the
// user must write it only while the block is idle, as the block itself does not enforce it.
`default_nettype none

`include "integer_to_radix_digits_unit_assert.svh"

module integer_to_radix_digits_unit #(
    parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // input items
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [itrd_pkg::S_TDATA_W-1:0]   s_tdata,   // [30:0] number_in, [31] zero pad
    // result items
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [itrd_pkg::M_TDATA_W-1:0]   m_tdata,   // [6:0] digit_char, [7] zero pad
    output logic                             m_tlast,   // last_digit
    // configuration
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [itrd_pkg::PADDR_W-1:0]     paddr,
    input  wire  [itrd_pkg::PDATA_W-1:0]     pwdata,
    output logic [itrd_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    localparam int CNT_W  = $clog2(2 * VALUE_BITS);
    localparam int DCNT_W = $clog2(VALUE_BITS + 1);
    localparam int TOP    = VALUE_BITS - 1;
    localparam logic [CNT_W-1:0]  CONV_LAST = CNT_W'(2 * VALUE_BITS - 2);
    localparam logic [CNT_W-1:0]  FEED_LEN  = CNT_W'(VALUE_BITS);
    localparam logic [DCNT_W-1:0] ALL_DIGITS = DCNT_W'(VALUE_BITS);
    localparam logic [DCNT_W-1:0] ONE_DIGIT  = DCNT_W'(1);

    itrd_pkg::state_t                state_reg, state_next;
    logic [itrd_pkg::RADIX_W-1:0]    radix_reg;
    logic [itrd_pkg::RADIX_W-1:0]    eff_radix;
    logic [VALUE_BITS-1:0]           val_reg;
    logic [VALUE_BITS-1:0]           num_ext;
    logic [CNT_W-1:0]                cyc_reg;
    logic [DCNT_W-1:0]               dcnt_reg;
    logic                            m_tvalid_reg;
    logic [itrd_pkg::CHAR_W-1:0]     m_char_reg;
    logic                            m_last_reg;

    itrd_pkg::cell_ctrl_t            cell_ctrl;
    itrd_pkg::cell_mode_t            cell_mode;
    logic                            accept;
    logic                            out_load;
    logic                            cfg_write;
    logic                            top_zero;
    logic                            one_left;

    // carry chain, entry 0 is the serial bit fed into the bottom cell
    logic                            carry_v [VALUE_BITS+1];
    logic                            carry   [VALUE_BITS+1];
    logic [itrd_pkg::DIGIT_W-1:0]    digit   [VALUE_BITS];

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == itrd_pkg::REG_RADIX);

    always_comb begin
        if (paddr[2] == itrd_pkg::REG_RADIX) begin
            prdata = itrd_pkg::PDATA_W'(radix_reg);
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= itrd_pkg::RADIX_RESET;
        end else if (cfg_write) begin
            radix_reg <= pwdata[itrd_pkg::RADIX_W-1:0];
        end
    end

    // out-of-range radix codes clamp to the nearest legal base
    always_comb begin
        if (radix_reg < itrd_pkg::RADIX_MIN) begin
            eff_radix = itrd_pkg::RADIX_MIN;
        end else if (radix_reg > itrd_pkg::RADIX_MAX) begin
            eff_radix = itrd_pkg::RADIX_MAX;
        end else begin
            eff_radix = radix_reg;
        end
    end

    // ---------------- input width fit ----------------
    generate
        if (VALUE_BITS <= itrd_pkg::NUMBER_W) begin : g_narrow
            assign num_ext = s_tdata[VALUE_BITS-1:0];
        end else begin : g_wide
            assign num_ext = VALUE_BITS'(s_tdata[itrd_pkg::NUMBER_W-1:0]);
        end
    endgenerate

    // ---------------- handshakes ----------------
    assign s_tready = (state_reg == itrd_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == itrd_pkg::ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign top_zero = (digit[TOP] == '0);
    assign one_left = (dcnt_reg == ONE_DIGIT);

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            itrd_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = itrd_pkg::ST_CONV;
                end
            end
            itrd_pkg::ST_CONV: begin
                if (cyc_reg == CONV_LAST) begin
                    state_next = itrd_pkg::ST_STRIP;
                end
            end
            itrd_pkg::ST_STRIP: begin
                // stop at the first nonzero digit, keep at least one
                if (!top_zero || one_left) begin
                    state_next = itrd_pkg::ST_EMIT;
                end
            end
            itrd_pkg::ST_EMIT: begin
                if (out_load && one_left) begin
                    state_next = itrd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = itrd_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- cell row control ----------------
    always_comb begin
        cell_mode = itrd_pkg::CELL_HOLD;
        unique case (state_reg)
            itrd_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cell_mode = itrd_pkg::CELL_CLEAR;
                end
            end
            itrd_pkg::ST_CONV: begin
                cell_mode = itrd_pkg::CELL_CONV;
            end
            itrd_pkg::ST_STRIP: begin
                if (top_zero && !one_left) begin
                    cell_mode = itrd_pkg::CELL_SHIFT;
                end
            end
            itrd_pkg::ST_EMIT: begin
                if (out_load) begin
                    cell_mode = itrd_pkg::CELL_SHIFT;
                end
            end
            default: begin
                cell_mode = itrd_pkg::CELL_HOLD;
            end
        endcase
    end

    assign cell_ctrl.mode  = cell_mode;
    assign cell_ctrl.radix = eff_radix;

    // serial feed: number bits msb first, until all VALUE_BITS bits have entered the bottom cell
    assign carry_v[0] = (state_reg == itrd_pkg::ST_CONV) && (cyc_reg < FEED_LEN);
    assign carry[0]   = val_reg[VALUE_BITS-1];

    generate
        for (genvar i = 0; i < VALUE_BITS; i++) begin : g_cell
            logic [itrd_pkg::DIGIT_W-1:0] shift_src;
            if (i == 0) begin : g_bottom
                assign shift_src = '0;
            end else begin : g_upper
                assign shift_src = digit[i-1];
            end
            itrd_cell u_cell (
                .aclk            (aclk),
                .aresetn         (aresetn),
                .ctrl            (cell_ctrl),
                .carry_in_valid  (carry_v[i]),
                .carry_in        (carry[i]),
                .shift_in        (shift_src),
                .digit           (digit[i]),
                .carry_out_valid (carry_v[i+1]),
                .carry_out       (carry[i+1])
            );
        end
    endgenerate

    // ---------------- sequencing registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= itrd_pkg::ST_IDLE;
            cyc_reg      <= '0;
            dcnt_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                cyc_reg <= '0;
            end else if (state_reg == itrd_pkg::ST_CONV) begin
                cyc_reg <= cyc_reg + CNT_W'(1);
                if (cyc_reg == CONV_LAST) begin
                    dcnt_reg <= ALL_DIGITS;
                end
            end else if (cell_mode == itrd_pkg::CELL_SHIFT) begin
                dcnt_reg <= dcnt_reg - ONE_DIGIT;
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end

        // payload
        if (accept) begin
            val_reg <= num_ext;
        end else if (state_reg == itrd_pkg::ST_CONV) begin
            val_reg <= {val_reg[VALUE_BITS-2:0], 1'b0};
        end
        if (out_load) begin
            m_char_reg <= itrd_pkg::digit_to_char(digit[TOP]);
            m_last_reg <= one_left;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = itrd_pkg::M_TDATA_W'(m_char_reg);
    assign m_tlast  = m_last_reg;

    // ---------------- assertions ----------------
    // the row has room for every digit, so the top cell never carries out
    `ITRD_ASSERT_NOW(a_no_overflow, carry_v[VALUE_BITS], !carry[VALUE_BITS],
                     "digit row overflow")
    `ITRD_ASSERT_NEXT(a_accept_starts, accept,
                      (state_reg == itrd_pkg::ST_CONV) && (cyc_reg == '0),
                      "conversion did not start")
    `ITRD_ASSERT_NOW(a_count_live,
                     (state_reg == itrd_pkg::ST_STRIP) || (state_reg == itrd_pkg::ST_EMIT),
                     dcnt_reg != '0, "digit count ran out")
    `ITRD_ASSERT_NOW(a_digit_range, state_reg == itrd_pkg::ST_STRIP,
                     itrd_pkg::RADIX_W'(digit[TOP]) < eff_radix, "digit not below radix")
    `ITRD_ASSERT_NEXT(a_last_ends, out_load && one_left,
                      (state_reg == itrd_pkg::ST_IDLE) && m_tlast && m_tvalid,
                      "final digit did not end the number")

endmodule

`default_nettype wire
